>>> design/assert_macros.svh
// Assertion helpers; the enclosing module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds on the same edge
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds -> cons holds on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// cond never holds
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> design/rq_pkg.sv
package rq_pkg;

	localparam int CAP_W = 6;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_REM = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		RES_HOLD = 2'd0,
		RES_FAIL = 2'd1,
		RES_ENQ  = 2'd2,
		RES_TAKE = 2'd3
	} res_sel_t;

	typedef enum logic [1:0] {
		RD_CUR   = 2'd0,
		RD_NEXT  = 2'd1,
		RD_AFTER = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic     load;
		logic     enq;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     idx_clr;
		logic     idx_inc;
		logic     shift_wr;
		logic     cnt_dec;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic can_enq;
		logic empty;
		logic id_match;
		logic more1;
		logic more2;
	} sts_t;

endpackage

>>> design/rq_datapath.sv
`include "assert_macros.svh"

module rq_datapath import rq_pkg::*; #(
	parameter int DEPTH   = 32,
	parameter int ID_BITS = 8,
	parameter int CNT_W   = 6,
	parameter int IN_TW   = 40,
	parameter int OUT_TW  = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [IN_TW-1:0]  s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              cfg_valid,
	input  logic [CAP_W-1:0]  cfg_data,
	output logic [OUT_TW-1:0] m_tdata,
	output logic              m_tuser
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENT_W = ID_BITS + 32;
	localparam int CMP_W = CNT_W + CAP_W;
	localparam int NXT_W = CNT_W + 2;

	logic [ENT_W-1:0]   mem [DEPTH];
	logic [ENT_W-1:0]   rdata_q;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	logic [ENT_W-1:0]   wdata;
	logic               we;

	logic [CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	op_t                op_q;
	logic [ID_BITS-1:0] key_q;
	logic [31:0]        hdl_q;

	logic               res_ok_q;
	logic [ID_BITS-1:0] res_id_q;
	logic [31:0]        res_h_q;

	logic               out_ok_q;
	logic [ID_BITS-1:0] out_id_q;
	logic [31:0]        out_h_q;
	logic [CNT_W-1:0]   out_cnt_q;

	logic [NXT_W-1:0]   idx_ext;
	logic [NXT_W-1:0]   cnt_ext;

	assign idx_ext = NXT_W'(idx_q);
	assign cnt_ext = NXT_W'(count_q);

	always_comb begin
		case (cmd.rd_sel)
			RD_NEXT:  raddr = IDX_W'(idx_ext + NXT_W'(1));
			RD_AFTER: raddr = IDX_W'(idx_ext + NXT_W'(2));
			default:  raddr = idx_q;
		endcase
	end

	assign we    = cmd.enq | cmd.shift_wr;
	assign waddr = cmd.enq ? count_q[IDX_W-1:0] : idx_q;
	assign wdata = cmd.enq ? {key_q, hdl_q} : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.enq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= IDX_W'(idx_ext + NXT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(s_tuser);
			key_q <= s_tdata[ID_BITS-1:0];
			hdl_q <= s_tdata[ID_BITS+31:ID_BITS];
		end
		unique case (cmd.res_sel)
			RES_HOLD: ;
			RES_FAIL: begin
				res_ok_q <= 1'b0;
				res_id_q <= '0;
				res_h_q  <= '0;
			end
			RES_ENQ: begin
				res_ok_q <= 1'b1;
				res_id_q <= '0;
				res_h_q  <= '0;
			end
			RES_TAKE: begin
				res_ok_q <= 1'b1;
				res_id_q <= rdata_q[ENT_W-1:32];
				res_h_q  <= rdata_q[31:0];
			end
		endcase
		if (cmd.out_load) begin
			out_ok_q  <= res_ok_q;
			out_id_q  <= res_id_q;
			out_h_q   <= res_h_q;
			out_cnt_q <= count_q;
		end
	end

	assign sts.op       = op_q;
	assign sts.can_enq  = (count_q < CNT_W'(DEPTH)) && (CMP_W'(count_q) < CMP_W'(cap_q));
	assign sts.empty    = (count_q == '0);
	assign sts.id_match = (rdata_q[ENT_W-1:32] == key_q);
	assign sts.more1    = (idx_ext + NXT_W'(1)) < cnt_ext;
	assign sts.more2    = (idx_ext + NXT_W'(2)) < cnt_ext;

	assign m_tdata = OUT_TW'({out_cnt_q, out_h_q, out_id_q});
	assign m_tuser = out_ok_q;

	`ASSERT_IMPL(a_enq_room, cmd.enq, count_q < CNT_W'(DEPTH), "enqueue write past depth")
	`ASSERT_IMPL(a_shift_range, cmd.shift_wr, sts.more1, "shift source beyond tail")
	`ASSERT_IMPL(a_dec_nonempty, cmd.cnt_dec, count_q != '0, "count underflow")

endmodule

>>> design/rq_ctrl.sv
`include "assert_macros.svh"

module rq_ctrl import rq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DISP   = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.op) inside
					OP_ENQ: begin
						if (sts.can_enq) begin
							cmd.enq     = 1'b1;
							cmd.res_sel = RES_ENQ;
						end else begin
							cmd.res_sel = RES_FAIL;
						end
						state_d = ST_FINISH;
					end
					OP_DEQ, OP_REM: begin
						if (sts.empty) begin
							cmd.res_sel = RES_FAIL;
							state_d     = ST_FINISH;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_CUR;
							state_d    = ST_CHECK;
						end
					end
					default: begin
						cmd.res_sel = RES_FAIL;
						state_d     = ST_FINISH;
					end
				endcase
			end
			ST_CHECK: begin
				if (sts.op == OP_DEQ || sts.id_match) begin
					cmd.res_sel = RES_TAKE;
					if (sts.more1) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NEXT;
						state_d    = ST_SHIFT;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_d     = ST_FINISH;
					end
				end else if (sts.more1) begin
					cmd.idx_inc = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_NEXT;
				end else begin
					cmd.res_sel = RES_FAIL;
					state_d     = ST_FINISH;
				end
			end
			ST_SHIFT: begin
				cmd.shift_wr = 1'b1;
				cmd.idx_inc  = 1'b1;
				if (sts.more2) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_AFTER;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	`ASSERT_IMPL(a_out_free, cmd.out_load, !m_valid_q || m_tready, "result word overwritten")
	`ASSERT_NEXT(a_accept_disp, s_tvalid && s_tready, state_q == ST_DISP, "accept lost")
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")

endmodule

>>> design/ready_queue_with_remove_by_id.sv
// Bounded FIFO ready queue of thread entries with remove by thread id.
// Input stream: s_tuser carries the operation (enqueue, dequeue head, remove
// by id), s_tdata the thread id and handle. Output stream: one result word per
// input word; m_tuser is the success flag, m_tdata the returned entry and the
// entry count after the operation.
// cfg_valid/cfg_data write the capacity limit (reset 32, clipped to DEPTH);
// write it only while the queue is idle. cfg_ready is always high.
// The queue takes one word at a time. Enqueue, and any operation on an
// empty queue, goes from dispatch straight to finish; dequeue and remove
// otherwise pass through check, and shift where needed, with the entry store
// doing at most one read and one write per cycle to scan and close the gap.
// A new word is accepted the cycle after the previous result enters the
// output register; that register holds the word while m_tready is low, so a
// stalled receiver delays only the following result.
// Reset empties the queue (count 0) and restores the capacity limit; entry
// contents are not cleared.
module ready_queue_with_remove_by_id import rq_pkg::*; #(
	parameter  int DEPTH   = 32,
	parameter  int ID_BITS = 8,
	localparam int CNT_W   = $clog2(DEPTH + 1),
	localparam int IN_TW   = ((ID_BITS + 32 + 7) / 8) * 8,
	localparam int OUT_TW  = ((ID_BITS + 32 + CNT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,   // thread_id, handle
	input  logic [1:0]        s_tuser,   // op
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,   // out_thread_id, out_handle, count
	output logic              m_tuser,   // ok
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data   // capacity_limit
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rq_datapath #(
		.DEPTH   (DEPTH),
		.ID_BITS (ID_BITS),
		.CNT_W   (CNT_W),
		.IN_TW   (IN_TW),
		.OUT_TW  (OUT_TW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
